// ===== rtl/ceba_pkg.sv =====
`default_nettype none

package ceba_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned START_W   = 6;
  localparam int unsigned LEN_W     = 14;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned USED_W    = 7;
  localparam int unsigned EC_W      = 7;
  localparam int unsigned EB_W      = 8;
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 16;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_BYTES = 2'd1;

  localparam logic [EC_W-1:0] ENTRY_COUNT_RST = 7'd64;
  localparam logic [EB_W-1:0] ENTRY_BYTES_RST = 8'd16;

  // dividend is length plus divisor minus one, one bit wider than the length
  localparam int unsigned DIV_W     = LEN_W + 1;
  localparam int unsigned DIV_CNT_W = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_MARK    = 2'd2,
    OP_PACK    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_COMPACT = 2'd1,
    ST_EVICT   = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_SCAN,
    S_FILL,
    S_RANGE,
    S_COUNT,
    S_PACK,
    S_DONE
  } fsm_e;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [EB_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/ceba_ram.sv =====
`default_nettype none

module ceba_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/ceba_div.sv =====
`default_nettype none

module ceba_div (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ceba_pkg::div_req_t  req_i,
  output ceba_pkg::div_rsp_t       rsp_o
);

  localparam int unsigned DW = ceba_pkg::DIV_W;
  localparam int unsigned BW = ceba_pkg::EB_W;
  localparam int unsigned CW = ceba_pkg::DIV_CNT_W;

  logic [BW:0]   rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [BW-1:0] dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;

  logic [BW:0]   rem_sh;
  logic [BW:0]   diff;
  logic          ge;

  // restoring division, one quotient bit a cycle, msb first
  always_comb begin
    rem_sh = {rem_q[BW-1:0], quo_q[DW-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    diff   = rem_sh - {1'b0, dvs_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff : rem_sh;
      quo_d = {quo_q[DW-2:0], ge};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

// ===== rtl/contiguous_entry_bitmap_allocator.sv =====
`default_nettype none

// First-fit allocator over a bitmap of fixed-size storage entries, kept in a one-bit-wide
// RAM of MAX_ENTRIES words and walked one entry a cycle by a small sequencer. After reset
// the block sweeps every RAM word clear before it raises s_axis_tready. One beat is taken
// at a time; an allocate runs a check, a serial ceiling division, a scan of the active
// entries, a fill of the allocated entries and a hand-over; release and mark run the check,
// the division, a walk over the active entries and the hand-over; pack counts and rewrites
// the bitmap; for an invalid length the used entries are counted before the reply. The bitmap
// walks go through the RAM read port. A finished result waits in an output register so the
// next beat can be taken.

module contiguous_entry_bitmap_allocator #(
  parameter int unsigned MAX_ENTRIES = ceba_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration writes
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [ceba_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [ceba_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // request stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // start_entry [5:0], value_length [19:6], zero [23:20]
  input  wire logic [ceba_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // opcode [1:0]
  input  wire logic [ceba_pkg::OP_W-1:0]       s_axis_tuser,
  // result stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // found_start [5:0], used_entries [12:6], zero [15:13]
  output logic      [ceba_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // status [1:0]
  output logic      [ceba_pkg::STATUS_W-1:0]   m_axis_tuser
);

  localparam int unsigned AW    = $clog2(MAX_ENTRIES);
  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned WW    = ((IDX_W > ceba_pkg::USED_W) ? IDX_W : ceba_pkg::USED_W) + 1;
  localparam int unsigned PW0   = IDX_W + ceba_pkg::EB_W;
  localparam int unsigned PW    = (PW0 > ceba_pkg::LEN_W) ? PW0 : ceba_pkg::LEN_W;
  localparam int unsigned SW    = ceba_pkg::START_W;
  localparam int unsigned LW    = ceba_pkg::LEN_W;
  localparam int unsigned UW    = ceba_pkg::USED_W;
  localparam int unsigned DW    = ceba_pkg::DIV_W;

  ceba_pkg::fsm_e    state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  ceba_pkg::op_e     op_q, op_d;
  logic [SW-1:0]     start_q, start_d;
  logic [LW-1:0]     len_q, len_d;
  logic [IDX_W-1:0]  k_q, k_d;
  logic [IDX_W-1:0]  end_q, end_d;
  logic [IDX_W-1:0]  free_q, free_d;
  logic [IDX_W-1:0]  run_q, run_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  found_q, found_d;
  logic              hit_q, hit_d;
  ceba_pkg::status_e status_q, status_d;

  logic              rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic              rd_inr_q, rd_inr_d;

  logic [ceba_pkg::EC_W-1:0] ecount_q;
  logic [ceba_pkg::EB_W-1:0] ebytes_q;

  logic              m_valid_q, m_valid_d;
  ceba_pkg::status_e out_status_q;
  logic [SW-1:0]     out_found_q;
  logic [UW-1:0]     out_used_q;
  logic              out_load;

  logic              ram_we;
  logic              ram_wdata;
  logic              ram_rdata;
  logic [AW-1:0]     ram_addr;

  ceba_pkg::div_req_t div_req;
  ceba_pkg::div_rsp_t div_rsp;

  logic [WW-1:0]     n_w;
  logic [IDX_W-1:0]  n;
  logic [ceba_pkg::EB_W-1:0] b;
  logic [PW0-1:0]    prod;
  logic              issue;
  logic              inr;
  logic              walk_done;
  logic [IDX_W-1:0]  run_n;
  logic [WW-1:0]     found_w;
  logic [WW-1:0]     used_w;

  // active entry count and effective entry size
  always_comb begin
    n_w  = (WW'(ecount_q) > WW'(MAX_ENTRIES)) ? WW'(MAX_ENTRIES) : WW'(ecount_q);
    n    = n_w[IDX_W-1:0];
    b    = (ebytes_q == '0) ? ceba_pkg::EB_W'(1) : ebytes_q;
    prod = PW0'(n) * PW0'(b);
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecount_q <= ceba_pkg::ENTRY_COUNT_RST;
      ebytes_q <= ceba_pkg::ENTRY_BYTES_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == ceba_pkg::CFG_ENTRY_COUNT) begin
        ecount_q <= cfg_data_i[ceba_pkg::EC_W-1:0];
      end else if (cfg_index_i == ceba_pkg::CFG_ENTRY_BYTES) begin
        ebytes_q <= cfg_data_i[ceba_pkg::EB_W-1:0];
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    op_d     = op_q;
    start_d  = start_q;
    len_d    = len_q;
    k_d      = k_q;
    end_d    = end_q;
    free_d   = free_q;
    run_d    = run_q;
    cnt_d    = cnt_q;
    found_d  = found_q;
    hit_d    = hit_q;
    status_d = status_q;
    rd_idx_d = idx_q;
    rd_inr_d = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = 1'b0;
    ram_addr  = idx_q[AW-1:0];
    out_load  = 1'b0;
    s_axis_tready = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = DW'(len_q) + DW'(b) - DW'(1);
    div_req.divisor  = b;

    // walk over the active entries, read data comes back in the next cycle
    issue     = 1'b0;
    if (state_q == ceba_pkg::S_SCAN || state_q == ceba_pkg::S_RANGE ||
        state_q == ceba_pkg::S_COUNT) begin
      issue = WW'(idx_q) < n_w;
    end
    walk_done = !issue && !rd_vld_q;
    rd_vld_d  = issue;
    if (issue) begin
      idx_d = idx_q + IDX_W'(1);
    end
    inr   = (WW'(idx_q) >= WW'(start_q)) && ((WW'(idx_q) - WW'(start_q)) < WW'(k_q));
    run_n = run_q + IDX_W'(1);

    case (state_q)
      ceba_pkg::S_CLEAR: begin
        ram_we = 1'b1;
        if (WW'(idx_q) == WW'(MAX_ENTRIES - 1)) begin
          idx_d   = '0;
          state_d = ceba_pkg::S_IDLE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ceba_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          op_d    = ceba_pkg::op_e'(s_axis_tuser);
          start_d = s_axis_tdata[SW-1:0];
          len_d   = s_axis_tdata[SW+LW-1:SW];
          state_d = ceba_pkg::S_CHECK;
        end
      end
      ceba_pkg::S_CHECK: begin
        idx_d    = '0;
        free_d   = '0;
        run_d    = '0;
        cnt_d    = '0;
        hit_d    = 1'b0;
        found_d  = '0;
        status_d = ceba_pkg::ST_DONE;
        if (op_q == ceba_pkg::OP_PACK) begin
          state_d = ceba_pkg::S_COUNT;
        end else if (len_q == '0 || PW'(len_q) > PW'(prod)) begin
          status_d = ceba_pkg::ST_INVALID;
          state_d  = ceba_pkg::S_COUNT;
        end else begin
          div_req.start = 1'b1;
          state_d       = ceba_pkg::S_DIV;
        end
      end
      ceba_pkg::S_DIV: begin
        if (div_rsp.done) begin
          k_d   = div_rsp.quotient[IDX_W-1:0];
          idx_d = '0;
          if (op_q == ceba_pkg::OP_ALLOC) begin
            state_d = ceba_pkg::S_SCAN;
          end else begin
            state_d = ceba_pkg::S_RANGE;
          end
        end
      end
      ceba_pkg::S_SCAN: begin
        if (rd_vld_q) begin
          if (ram_rdata) begin
            run_d = '0;
          end else begin
            free_d = free_q + IDX_W'(1);
            run_d  = run_n;
            if (!hit_q && run_n == k_q) begin
              hit_d   = 1'b1;
              found_d = rd_idx_q + IDX_W'(1) - k_q;
            end
          end
        end
        if (walk_done) begin
          if (hit_q) begin
            idx_d   = found_q;
            end_d   = found_q + k_q;
            cnt_d   = n - free_q + k_q;
            state_d = ceba_pkg::S_FILL;
          end else begin
            status_d = (k_q <= free_q) ? ceba_pkg::ST_COMPACT : ceba_pkg::ST_EVICT;
            cnt_d    = n - free_q;
            state_d  = ceba_pkg::S_DONE;
          end
        end
      end
      ceba_pkg::S_FILL: begin
        if (idx_q < end_q) begin
          ram_we    = 1'b1;
          ram_wdata = 1'b1;
          idx_d     = idx_q + IDX_W'(1);
        end else begin
          state_d = ceba_pkg::S_DONE;
        end
      end
      ceba_pkg::S_RANGE: begin
        // entries in the range take the new value, the rest keep what is read back
        if (issue && inr) begin
          ram_we    = 1'b1;
          ram_wdata = (op_q == ceba_pkg::OP_MARK);
          rd_inr_d  = 1'b1;
        end
        if (rd_vld_q) begin
          if (rd_inr_q) begin
            cnt_d = cnt_q + IDX_W'(op_q == ceba_pkg::OP_MARK);
          end else begin
            cnt_d = cnt_q + IDX_W'(ram_rdata);
          end
        end
        if (walk_done) begin
          state_d = ceba_pkg::S_DONE;
        end
      end
      ceba_pkg::S_COUNT: begin
        if (rd_vld_q) begin
          cnt_d = cnt_q + IDX_W'(ram_rdata);
        end
        if (walk_done) begin
          if (op_q == ceba_pkg::OP_PACK) begin
            idx_d   = '0;
            state_d = ceba_pkg::S_PACK;
          end else begin
            state_d = ceba_pkg::S_DONE;
          end
        end
      end
      ceba_pkg::S_PACK: begin
        if (WW'(idx_q) < n_w) begin
          ram_we    = 1'b1;
          ram_wdata = idx_q < cnt_q;
          idx_d     = idx_q + IDX_W'(1);
        end else begin
          state_d = ceba_pkg::S_DONE;
        end
      end
      ceba_pkg::S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ceba_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ceba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ceba_pkg::S_CLEAR;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      rd_vld_q <= rd_vld_d;
      hit_q    <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    start_q  <= start_d;
    len_q    <= len_d;
    k_q      <= k_d;
    end_q    <= end_d;
    free_q   <= free_d;
    run_q    <= run_d;
    cnt_q    <= cnt_d;
    found_q  <= found_d;
    status_q <= status_d;
    rd_idx_q <= rd_idx_d;
    rd_inr_q <= rd_inr_d;
  end

  // output register
  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    found_w = WW'(found_q);
    used_w  = WW'(cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= status_q;
      out_found_q  <= found_w[SW-1:0];
      out_used_q   <= used_w[UW-1:0];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {(ceba_pkg::M_TDATA_W - SW - UW)'(0), out_used_q, out_found_q};

  ceba_ram #(
    .WIDTH (1),
    .DEPTH (MAX_ENTRIES)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  ceba_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

`ifndef SYNTHESIS
  a_fail_no_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ceba_pkg::ST_DONE |-> m_axis_tdata[SW-1:0] == '0)
    else $error("failed or rejected request carries a start entry");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken while one is at work");

  a_div_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ceba_pkg::S_DIV)
    else $error("divider finished outside the division step");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ceba_pkg::S_DONE |-> WW'(cnt_q) <= n_w)
    else $error("used count exceeds active entries");

  a_no_write_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ceba_pkg::S_SCAN || state_q == ceba_pkg::S_COUNT ||
    state_q == ceba_pkg::S_IDLE |-> !ram_we)
    else $error("bitmap written during a read-only walk");
`endif

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
module testbench;
  import ceba_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 200;
  localparam int unsigned HOLD_CYCLES    = 1500;
  localparam int unsigned WATCHDOG_LIMIT = 6000;
  localparam int unsigned NUM_PHASES     = 9;

  typedef struct {
    op_e              op;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } request_t;

  typedef struct {
    status_e             status;
    logic [START_W-1:0]  found;
    logic [USED_W-1:0]   used;
  } reply_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_ENTRY_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [OP_W-1:0]       s_axis_tuser  = '0;

  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;

  contiguous_entry_bitmap_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial forever #2 clk_i = ~clk_i;

  // shadow of the block: registers and the used flags
  logic [EC_W-1:0] cfg_count = ENTRY_COUNT_RST;
  logic [EB_W-1:0] cfg_bytes = ENTRY_BYTES_RST;
  bit               used_map [MAX_ENTRIES_DEF];

  request_t request_q [$];
  reply_t   predicted_replies [$];

  int unsigned send_idle_pct = 33;
  int unsigned recv_idle_pct = 73;
  bit          hold_arm      = 1'b0;
  bit          hold_served   = 1'b0;
  int unsigned hold_left     = 0;

  bit          req_fire     = 1'b0;
  int unsigned error_count  = 0;
  int unsigned reply_index  = 0;
  int unsigned quiet_cycles = 0;
  request_t    beat_out;
  request_t    beat_in;
  reply_t      want;

  task automatic report_error(string msg);
    $display("ERROR: %s", msg);
    error_count++;
  endtask

  function automatic int unsigned used_in(int unsigned n);
    int unsigned c;
    c = 0;
    for (int unsigned i = 0; i < n; i++)
      if (used_map[i]) c++;
    return c;
  endfunction

  // applies one operation to the shadow map and returns the reply it should give
  function automatic reply_t apply_map_op(request_t r);
    int unsigned n, b, k, run, free_total, first, used;
    bit          hit;
    reply_t      res;
    n = (cfg_count > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : int'(cfg_count);
    b = (cfg_bytes == 0) ? 1 : int'(cfg_bytes);
    res.status = ST_DONE;
    first = 0;
    hit = 1'b0;
    if (r.op == OP_PACK) begin
      used = used_in(n);
      for (int unsigned i = 0; i < n; i++) used_map[i] = (i < used);
    end else if (r.len == 0 || r.len > n * b) begin
      res.status = ST_INVALID;
    end else begin
      k = (r.len + b - 1) / b;
      if (r.op == OP_ALLOC) begin
        run = 0;
        free_total = 0;
        for (int unsigned i = 0; i < n; i++) begin
          if (used_map[i]) begin
            run = 0;
          end else begin
            free_total++;
            run++;
            if (!hit && run == k) begin
              hit = 1'b1;
              first = i + 1 - k;
            end
          end
        end
        if (hit) begin
          for (int unsigned i = first; i < first + k; i++) used_map[i] = 1'b1;
        end else if (k <= free_total) begin
          res.status = ST_COMPACT;
        end else begin
          res.status = ST_EVICT;
        end
      end else begin
        for (int unsigned i = r.start; i < n && i - r.start < k; i++)
          used_map[i] = (r.op == OP_MARK);
      end
    end
    res.found = 6'(first);
    res.used  = 7'(used_in(n));
    return res;
  endfunction

  task automatic queue_request(op_e op, int unsigned start, int unsigned len);
    request_t r;
    r.op    = op;
    r.start = 6'(start);
    r.len   = 14'(len);
    request_q.push_back(r);
  endtask

  // mostly ranges that fit, with some runs over the whole map and a few bad lengths
  function automatic request_t random_request(int unsigned n, int unsigned b);
    request_t    r;
    int unsigned pick, span, k;
    pick = $urandom_range(99);
    if (pick < 45)      r.op = OP_ALLOC;
    else if (pick < 70) r.op = OP_RELEASE;
    else if (pick < 88) r.op = OP_MARK;
    else                r.op = OP_PACK;
    r.start = 6'($urandom_range(63));
    r.len   = 14'($urandom_range(16383));
    if (r.op != OP_PACK) begin
      if (n == 0 || $urandom_range(19) == 0) begin
        r.len = $urandom_range(1) ? 14'd0 : 14'($urandom_range(16383, n * b + 1));
      end else begin
        span = ($urandom_range(7) == 0) ? n : ((n / 6 > 0) ? n / 6 : 1);
        k = $urandom_range(span, 1);
        r.len = 14'((k - 1) * b + $urandom_range(b, 1));
        if ($urandom_range(3) != 0) r.start = 6'($urandom_range(n - 1));
      end
    end
    return r;
  endfunction

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_and_settle();
    while (request_q.size() != 0 || s_axis_tvalid || predicted_replies.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || req_fire)) begin
      if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        beat_out = request_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, beat_out.len, beat_out.start};
        s_axis_tuser  <= beat_out.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off to back the block up
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_arm && !hold_served) begin
      hold_left <= HOLD_CYCLES;
      hold_served <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: results are checked before the request beat of the same edge is predicted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      req_fire <= s_axis_tvalid && s_axis_tready;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_ENTRY_COUNT)      cfg_count = cfg_data_i[EC_W-1:0];
        else if (cfg_index_i == CFG_ENTRY_BYTES) cfg_bytes = cfg_data_i;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_replies.size() == 0) begin
          report_error($sformatf("result beat %0d with nothing expected", reply_index));
        end else begin
          want = predicted_replies.pop_front();
          if (m_axis_tuser !== want.status)
            report_error($sformatf("beat %0d status: got %0d expected %0d",
                                   reply_index, m_axis_tuser, want.status));
          if (m_axis_tdata[5:0] !== want.found)
            report_error($sformatf("beat %0d found_start: got %0d expected %0d",
                                   reply_index, m_axis_tdata[5:0], want.found));
          if (m_axis_tdata[12:6] !== want.used)
            report_error($sformatf("beat %0d used_entries: got %0d expected %0d",
                                   reply_index, m_axis_tdata[12:6], want.used));
        end
        reply_index++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        beat_in.op    = op_e'(s_axis_tuser);
        beat_in.start = s_axis_tdata[5:0];
        beat_in.len   = s_axis_tdata[19:6];
        predicted_replies.push_back(apply_map_op(beat_in));
      end
      if ((cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [7:0]  count_data, bytes_data;
    int unsigned n, b, items;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: 64 entries of 16 bytes
    queue_request(OP_ALLOC,   0, 1);
    queue_request(OP_ALLOC,   0, 16);
    queue_request(OP_ALLOC,   0, 17);
    queue_request(OP_ALLOC,   0, 0);
    queue_request(OP_ALLOC,   0, 1025);
    queue_request(OP_ALLOC,  63, 16383);
    queue_request(OP_RELEASE, 1, 16);
    queue_request(OP_MARK,   62, 48);      // runs past the last entry
    queue_request(OP_RELEASE, 63, 1024);
    queue_request(OP_ALLOC,   0, 1024);    // too few free entries
    queue_request(OP_ALLOC,   0, 944);     // enough free, but fragmented
    queue_request(OP_PACK,   17, 9999);
    queue_request(OP_ALLOC,   0, 960);     // exact fit at the top
    queue_request(OP_ALLOC,   0, 1);
    queue_request(OP_RELEASE, 0, 1024);
    queue_request(OP_MARK,   10, 32);
    queue_request(OP_RELEASE, 0, 0);
    queue_request(OP_MARK,    0, 0);
    queue_request(OP_MARK,   63, 1025);
    queue_request(OP_MARK,   63, 16);
    queue_request(OP_PACK,    0, 0);
    queue_request(OP_ALLOC,   0, 1024);
    queue_request(OP_RELEASE, 5, 1);
    queue_request(OP_ALLOC,   0, 31);
    drain_and_settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin count_data = 8'd64;  bytes_data = 8'd1;   items = 150; end
        1: begin count_data = 8'd1;   bytes_data = 8'd255; items = 60;  end
        2: begin count_data = 8'hFF;  bytes_data = 8'd0;   items = 150; end
        3: begin count_data = 8'h80;  bytes_data = 8'd200; items = 20;  end
        4: begin count_data = 8'd17;  bytes_data = 8'd3;   items = 150; end
        7: begin count_data = 8'd64;  bytes_data = 8'd255; items = 170; end
        8: begin count_data = 8'd40;  bytes_data = 8'd16;  items = 150; end
        default: begin
          count_data = 8'($urandom_range(64, 1));
          bytes_data = 8'($urandom_range(255, 1));
          items = 150;
        end
      endcase
      if (p < 3) begin
        send_idle_pct = 33;
        recv_idle_pct = 73;
      end else if (p < 6) begin
        send_idle_pct = 73;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_register(CFG_ENTRY_COUNT, count_data);
      write_register(CFG_ENTRY_BYTES, bytes_data);
      n = (count_data[6:0] > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : int'(count_data[6:0]);
      b = (bytes_data == 0) ? 1 : int'(bytes_data);
      for (int i = 0; i < items; i++) request_q.push_back(random_request(n, b));
      if (p == 0) hold_arm = 1'b1;
      drain_and_settle();
    end

    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
